[rtl/sre_pkg.sv]
// sre_pkg: shared types, command codes and constants for the static range encoder.
// No dependencies.
package sre_pkg;

  localparam int ALPHABET     = 256;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 17;
  localparam int SEGMENT_MAX_DEF = 65536;

  localparam logic [1:0] CMD_COUNT  = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] symbol;
  } sre_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       error;
  } sre_out_t;

  // request from the controller to the divider
  typedef struct packed {
    logic        start;
    logic [81:0] dividend;
    logic [16:0] divisor;
  } sre_div_req_t;

endpackage

[rtl/static_range_encoder.sv]
// Static range encoder for one segment of bytes.
// Channels: start/busy accept a beat {cmd, symbol} on in_item when start is high and
// busy is low. Results appear on out_result for one cycle, marked by out_strobe;
// the receiver cannot stall, so no result is ever held.
// Count: histogram read-modify-write (S_CNT_RD, then S_CNT_WR) in a one-port-read memory.
// Encode: first encode of a segment walks the histogram to build the prefix
// table, a read and a write per symbol. Each encode then reads the
// two tables, runs one or two 82-step serial divides (one when the symbol's
// cumulative count is zero) and emits up to 8 bytes, one per cycle.
// Flush: 8 byte beats, then a pass over all 256 entries clears the histogram.
// After reset a clearing pass over the histogram runs while busy is high.
// Errors (zero count, collapsed interval) give one beat with error set.
module static_range_encoder
  import sre_pkg::*;
#(
  parameter int SEGMENT_MAX = SEGMENT_MAX_DEF
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sre_in_t  in_item,
  output logic     out_strobe,
  output sre_out_t out_result
);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_CNT_RD = 5'd2,
    S_CNT_WR = 5'd3, S_PFX_RD = 5'd4, S_PFX_WR = 5'd5, S_ENC_RD = 5'd6,
    S_ENC_CHK = 5'd7, S_DIV1 = 5'd8, S_DIV1W = 5'd9, S_DIV2 = 5'd10,
    S_NARROW = 5'd12, S_EMIT = 5'd13, S_FLUSH = 5'd14,
    S_PFX_LAST = 5'd15;

  localparam logic [CNT_W-1:0] SEG_LIM = CNT_W'(SEGMENT_MAX);

  logic [CNT_W-1:0] hist_mem [ALPHABET];
  logic [CNT_W-1:0] cum_mem  [ALPHABET];
  logic [CNT_W-1:0] hist_q, cum_q;
  logic [SYM_W-1:0] hist_ra, hist_wa;
  logic [CNT_W-1:0] hist_wd;
  logic             hist_we, cum_we;
  logic [SYM_W-1:0] cum_wa;
  logic [CNT_W-1:0] cum_wd;

  logic [4:0]  st_r, st_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic [CNT_W-1:0] tot_r, tot_nxt, acc_r, acc_nxt, k_r, k_nxt, c_r, c_nxt;
  logic [63:0] low_r, low_nxt, high_r, high_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic [63:0] rng_r, rng_nxt;
  logic        pfx_r, pfx_nxt, phase_r, phase_nxt;
  logic [3:0]  n_r, n_nxt;
  logic        ostb;
  sre_out_t    ores;
  sre_div_req_t dreq;
  logic        ddone;
  logic [81:0] dquot;
  logic [17:0] mult_c;
  logic [81:0] prod;

  // Product c*range is built in two halves to keep each multiply narrow.
  logic [49:0] ph_r, pl_r;
  assign prod = {ph_r, 32'd0} + {32'd0, pl_r};

  sre_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

  always_ff @(posedge clk) begin
    hist_q <= hist_mem[hist_ra];
    cum_q  <= cum_mem[hist_ra];
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (cum_we)  cum_mem[cum_wa] <= cum_wd;
  end

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; sym_nxt = sym_r; tot_nxt = tot_r; acc_nxt = acc_r;
    k_nxt = k_r; c_nxt = c_r; low_nxt = low_r; high_nxt = high_r; hi_nxt = hi_r;
    lo_nxt = lo_r; rng_nxt = rng_r; pfx_nxt = pfx_r; n_nxt = n_r; phase_nxt = phase_r;
    hist_ra = sym_r; hist_we = 1'b0; hist_wa = sym_r; hist_wd = '0;
    cum_we = 1'b0; cum_wa = idx_r[7:0]; cum_wd = acc_r;
    ostb = 1'b0; ores = '0; dreq = '0;
    mult_c = phase_r ? {1'b0, c_r} : {1'b0, c_r} + {1'b0, k_r};
    case (st_r)
      S_CLR: begin
        hist_we = 1'b1; hist_wa = idx_r[7:0]; hist_wd = '0;
        idx_nxt = idx_r + 9'd1;
        if (idx_r == 9'd255) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        hist_ra = in_item.symbol;
        if (start) begin
          sym_nxt = in_item.symbol;
          case (in_item.cmd)
            CMD_COUNT:
              if (!pfx_r && tot_r < SEG_LIM) st_nxt = S_CNT_RD;
            CMD_ENCODE:
              if (pfx_r) st_nxt = S_ENC_RD;
              else begin
                st_nxt = S_PFX_RD; idx_nxt = '0; acc_nxt = '0;
              end
            CMD_FLUSH: begin
              st_nxt = S_FLUSH; n_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_CNT_RD: st_nxt = S_CNT_WR;
      S_CNT_WR: begin
        hist_we = 1'b1; hist_wd = hist_q + CNT_W'(1);
        tot_nxt = tot_r + CNT_W'(1); st_nxt = S_IDLE;
      end
      S_PFX_RD: begin
        hist_ra = idx_r[7:0]; st_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        cum_we = 1'b1; acc_nxt = acc_r + hist_q;
        if (idx_r == 9'd255) begin
          st_nxt = S_PFX_LAST; pfx_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 9'd1; st_nxt = S_PFX_RD;
        end
      end
      S_PFX_LAST: st_nxt = S_ENC_RD;
      S_ENC_RD: st_nxt = S_ENC_CHK;
      S_ENC_CHK: begin
        k_nxt = hist_q; c_nxt = cum_q; rng_nxt = high_r - low_r; phase_nxt = 1'b0;
        if (hist_q == '0 || tot_r == '0) begin
          ostb = 1'b1; ores = '{out_byte: 8'd0, last_of_run: 1'b1, error: 1'b1};
          st_nxt = S_IDLE;
        end else st_nxt = S_DIV1;
      end
      S_DIV1: st_nxt = S_DIV1W;
      S_DIV1W: begin
        dreq.start = 1'b1; dreq.dividend = prod; dreq.divisor = tot_r;
        st_nxt = S_DIV2;
      end
      S_DIV2: if (ddone) begin
        if (!phase_r) begin
          hi_nxt = low_r + dquot[63:0]; phase_nxt = 1'b1;
          if (c_r == '0) begin
            lo_nxt = low_r; st_nxt = S_NARROW;
          end else st_nxt = S_DIV1;
        end else begin
          lo_nxt = low_r + dquot[63:0] + 64'd1; st_nxt = S_NARROW;
        end
      end
      S_NARROW: begin
        n_nxt = '0;
        if (hi_r <= lo_r) begin
          ostb = 1'b1; ores = '{out_byte: 8'd0, last_of_run: 1'b1, error: 1'b1};
          st_nxt = S_IDLE;
        end else st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (lo_r[63:56] == hi_r[63:56] && n_r < 4'd8) begin
          ostb = 1'b1;
          ores.out_byte = lo_r[63:56];
          ores.last_of_run = !(lo_r[55:48] == hi_r[55:48] && n_r < 4'd7);
          lo_nxt = {lo_r[55:0], 8'h00}; hi_nxt = {hi_r[55:0], 8'hff};
          n_nxt = n_r + 4'd1;
        end else begin
          low_nxt = lo_r; high_nxt = hi_r; st_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        ostb = 1'b1; ores.out_byte = low_r[63:56]; ores.last_of_run = (n_r == 4'd7);
        low_nxt = {low_r[55:0], 8'h00}; n_nxt = n_r + 4'd1;
        if (n_r == 4'd7) begin
          low_nxt = '0; high_nxt = '1; tot_nxt = '0; pfx_nxt = 1'b0;
          idx_nxt = '0; st_nxt = S_CLR;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; idx_r <= '0; tot_r <= '0; low_r <= '0; high_r <= '1;
      pfx_r <= 1'b0; out_strobe <= 1'b0; phase_r <= 1'b0; n_r <= '0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; tot_r <= tot_nxt; low_r <= low_nxt;
      high_r <= high_nxt; pfx_r <= pfx_nxt; out_strobe <= ostb;
      phase_r <= phase_nxt; n_r <= n_nxt;
    end
    sym_r <= sym_nxt; acc_r <= acc_nxt; k_r <= k_nxt; c_r <= c_nxt;
    hi_r <= hi_nxt; lo_r <= lo_nxt; rng_r <= rng_nxt; out_result <= ores;
    ph_r <= 50'(mult_c) * 50'(rng_r[63:32]);
    pl_r <= 50'(mult_c) * 50'(rng_r[31:0]);
  end

  assign busy = (st_r != S_IDLE);

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || !out_strobe)) else $error("result without work");
  a_total_lim: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= SEG_LIM) else $error("segment total over limit");
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 4'd8) else $error("emit count overflow");

endmodule

[rtl/sre_div.sv]
// sre_div: restoring divider, one quotient bit per cycle, 82-bit dividend by 17-bit divisor.
// Depends on sre_pkg.
module sre_div
  import sre_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  sre_div_req_t req,
  output logic         done,
  output logic [81:0]  quot
);

  logic [81:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[16:0], q_r[81]};
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; cnt_nxt = 7'd82; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[80:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[80:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (req.start) d_r <= req.divisor;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[tb/static_range_encoder_tb.sv]
// static_range_encoder_tb: self-checking bench for the static range encoder.
// Uses sre_pkg and rtl/static_range_encoder.sv. A directed table, then random
// segments under several sender idle patterns, all checked against an in-bench coder model.
module static_range_encoder_tb;
  import sre_pkg::*;

  // cmd value the block ignores
  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] symbol;
    bit         typed;   // expect one error beat, typed in
  } row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sre_in_t  in_item;
  logic     out_strobe;
  sre_out_t out_result;

  static_range_encoder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_result(out_result)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // coder state
  logic [16:0] hist [ALPHABET];
  logic [16:0] cum_below [ALPHABET];
  logic [16:0] seg_total;
  logic [63:0] ivl_low, ivl_high;
  bit          prefix_built;

  sre_out_t expected_beats [$];
  int       fail_count, beats_checked, items_sent, error_beats, idle_pct;
  bit       typed_row;

  function automatic logic [63:0] share_of(logic [17:0] c, logic [63:0] r, logic [16:0] t);
    logic [81:0] prod;
    prod = c * r;
    return 64'(prod / t);
  endfunction

  task automatic coder_reset();
    for (int i = 0; i < ALPHABET; i++) hist[i] = '0;
    seg_total = '0;
    ivl_low = '0;
    ivl_high = '1;
    prefix_built = 0;
  endtask

  task automatic push_beat(logic [7:0] b, logic last, logic err);
    sre_out_t o;
    o.out_byte = b;
    o.last_of_run = last;
    o.error = err;
    expected_beats.push_back(o);
  endtask

  task automatic predict_beats(sre_in_t it);
    logic [17:0] c, k;
    logic [63:0] r, lo, hi;
    logic [16:0] acc;
    int n;
    n = 0;
    case (it.cmd)
      CMD_COUNT: begin
        if (!prefix_built && seg_total < 17'(SEGMENT_MAX_DEF)) begin
          hist[it.symbol]++;
          seg_total++;
        end
      end
      CMD_ENCODE: begin
        if (!prefix_built) begin
          acc = '0;
          for (int i = 0; i < ALPHABET; i++) begin
            cum_below[i] = acc;
            acc += hist[i];
          end
          prefix_built = 1;
        end
        k = hist[it.symbol];
        if (k == 0 || seg_total == 0) begin
          push_beat(8'h00, 1'b1, 1'b1);
        end else begin
          c = cum_below[it.symbol];
          r = ivl_high - ivl_low;
          hi = ivl_low + share_of(c + k, r, seg_total);
          lo = (c == 0) ? ivl_low : ivl_low + share_of(c, r, seg_total) + 64'd1;
          if (hi <= lo) begin
            push_beat(8'h00, 1'b1, 1'b1);
          end else begin
            while (lo[63:56] == hi[63:56] && n < 8) begin
              push_beat(lo[63:56], 1'b0, 1'b0);
              n++;
              lo = lo << 8;
              hi = {hi[55:0], 8'hff};
            end
            if (n > 0) expected_beats[$].last_of_run = 1'b1;
            ivl_low = lo;
            ivl_high = hi;
          end
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < 8; i++) push_beat(ivl_low[63 - 8 * i -: 8], i == 7, 1'b0);
        coder_reset();
      end
      default: ;
    endcase
  endtask

  // input beat accepted: predict
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      int before_n;
      before_n = expected_beats.size();
      predict_beats(in_item);
      if (typed_row) begin
        while (expected_beats.size() > before_n) void'(expected_beats.pop_back());
        push_beat(8'h00, 1'b1, 1'b1);
      end
    end
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sre_out_t e;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_result);
        fail_count++;
      end else begin
        e = expected_beats.pop_front();
        beats_checked++;
        if (out_result.error) error_beats++;
        if (out_result.out_byte !== e.out_byte) begin
          $error("out_byte: expected %h, got %h", e.out_byte, out_result.out_byte);
          fail_count++;
        end
        if (out_result.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %b, got %b", e.last_of_run, out_result.last_of_run);
          fail_count++;
        end
        if (out_result.error !== e.error) begin
          $error("error: expected %b, got %b", e.error, out_result.error);
          fail_count++;
        end
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] sym, bit typed = 0);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= '{cmd: cmd, symbol: sym};
    typed_row <= typed;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  // one well-formed segment with random content, some noise mixed in
  task automatic random_segment();
    logic [7:0] pool [4];
    int n_cnt, n_enc;
    for (int i = 0; i < 4; i++) pool[i] = 8'($urandom);
    n_cnt = $urandom_range(1, 16);
    n_enc = $urandom_range(1, 12);
    for (int i = 0; i < n_cnt; i++)
      send(CMD_COUNT, ($urandom_range(9) < 7) ? pool[0] : pool[$urandom_range(3)]);
    for (int i = 0; i < n_enc; i++) begin
      case ($urandom_range(19))
        0: send(CMD_ENCODE, 8'($urandom));          // mostly uncounted
        1: send(CMD_COUNT, 8'($urandom));           // ignored after encode
        2: send(CMD_RSVD, 8'($urandom));            // unused code
        default: send(CMD_ENCODE, pool[$urandom_range(3)]);
      endcase
    end
    send(CMD_FLUSH, 8'($urandom));
  endtask

  row_t directed [] = '{
    '{CMD_ENCODE, 8'h00, 1},   // empty segment: refused
    '{CMD_FLUSH,  8'h00, 0},   // low is zero after reset
    '{CMD_RSVD,   8'hff, 0},
    '{CMD_COUNT,  8'h00, 0},
    '{CMD_COUNT,  8'hff, 0},
    '{CMD_COUNT,  8'hff, 0},
    '{CMD_COUNT,  8'h80, 0},
    '{CMD_ENCODE, 8'h01, 1},   // zero count
    '{CMD_ENCODE, 8'h00, 0},
    '{CMD_ENCODE, 8'hff, 0},
    '{CMD_COUNT,  8'h01, 0},   // ignored, encoding started
    '{CMD_ENCODE, 8'h01, 1},
    '{CMD_ENCODE, 8'h80, 0},
    '{CMD_ENCODE, 8'hff, 0},
    '{CMD_ENCODE, 8'h00, 0},
    '{CMD_FLUSH,  8'hff, 0},
    '{CMD_COUNT,  8'h5a, 0},
    '{CMD_ENCODE, 8'h5a, 0},   // sole symbol: nothing to emit
    '{CMD_ENCODE, 8'h5a, 0},
    '{CMD_FLUSH,  8'h00, 0}
  };

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    typed_row = 0;
    idle_pct = 0;
    coder_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send(directed[i].cmd, directed[i].symbol, directed[i].typed);
    @(negedge clk);
    typed_row <= 0;
    drain();

    // phases: no idling, sender idle 81%, no idling again, sender idle 17%
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 81 : (p == 3) ? 17 : 0;
      for (int s = 0; s < 2; s++) random_segment();
      drain();   // sender holds off until all beats are back
    end

    repeat (600) @(negedge clk);
    $display("Ran %0d input beats, %0d result beats checked (%0d with error set).",
             items_sent, beats_checked, error_beats);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
